// ===== rtl/core/bcc_pkg.sv =====
// ----------------------------------------------------------------------------
// bcc_pkg
// Shared types and constants for the button click classifier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bcc_pkg;

    localparam int TIME_WIDTH  = 32;
    localparam int CFG_WIDTH   = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int COUNT_WIDTH = 2;

    typedef logic [TIME_WIDTH-1:0]  time_t;
    typedef logic [CFG_WIDTH-1:0]   cfg_word_t;
    typedef logic [COUNT_WIDTH-1:0] count_t;

    typedef enum logic [1:0] {
        EV_SINGLE = 2'd0,
        EV_LONG   = 2'd1,
        EV_DOUBLE = 2'd2
    } click_ev_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEBOUNCE   = 2'd0,
        REG_LONG_CLICK = 2'd1,
        REG_DOUBLE_GAP = 2'd2
    } cfg_idx_t;

    localparam cfg_word_t DEBOUNCE_RESET   = 16'd50;
    localparam cfg_word_t LONG_CLICK_RESET = 16'd300;
    localparam cfg_word_t DOUBLE_GAP_RESET = 16'd300;

    typedef struct packed {
        cfg_word_t debounce;
        cfg_word_t long_click;
        cfg_word_t double_gap;
    } bcc_cfg_t;

    typedef struct packed {
        logic      valid;
        click_ev_t ev;
    } bcc_result_t;

endpackage

`default_nettype wire

// ===== rtl/core/button_click_classifier.sv =====
// ----------------------------------------------------------------------------
// button_click_classifier
// Single, long and double click detector on a sampled button level.
// ----------------------------------------------------------------------------
// Each input word is one millisecond tick of the button level (0 pressed).
// A word is taken every cycle while in_stall is low, and classified in the
// same cycle; a resulting click_event (0 single, 1 long, 2 double) is queued
// in a two-entry output buffer and leaves it in order. in_stall rises only
// while it holds two undelivered words. Thresholds are to be written via
// cfg_we / cfg_index / cfg_data only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module button_click_classifier (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic                          button_level,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [1:0]                         click_event,
    input  wire logic                          cfg_we,
    input  wire logic [bcc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [bcc_pkg::CFG_WIDTH-1:0] cfg_data
);
    import bcc_pkg::*;

    bcc_cfg_t    cfg;
    bcc_result_t result;
    logic        full;
    logic        take;

    assign in_stall = full;
    assign take     = in_valid && !full;

    bcc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bcc_classify u_classify (
        .clk    (clk),
        .rst_n  (rst_n),
        .take   (take),
        .level  (button_level),
        .cfg    (cfg),
        .result (result)
    );

    bcc_out_buf u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (result),
        .full        (full),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .click_event (click_event)
    );

endmodule

`default_nettype wire

// ===== rtl/core/bcc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// bcc_cfg_regs
// Threshold registers written through the plain configuration write port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bcc_cfg_regs (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_we,
    input  wire logic [bcc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [bcc_pkg::CFG_WIDTH-1:0] cfg_data,
    output bcc_pkg::bcc_cfg_t               cfg
);
    import bcc_pkg::*;

    bcc_cfg_t cfg_reg;
    bcc_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_DEBOUNCE:   cfg_next.debounce   = cfg_data;
                REG_LONG_CLICK: cfg_next.long_click = cfg_data;
                REG_DOUBLE_GAP: cfg_next.double_gap = cfg_data;
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce   <= DEBOUNCE_RESET;
            cfg_reg.long_click <= LONG_CLICK_RESET;
            cfg_reg.double_gap <= DOUBLE_GAP_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== rtl/core/bcc_classify.sv =====
// ----------------------------------------------------------------------------
// bcc_classify
// Tick counter, edge detection and click classification for one sample word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bcc_classify (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           take,
    input  wire logic           level,
    input  wire bcc_pkg::bcc_cfg_t cfg,
    output bcc_pkg::bcc_result_t result
);
    import bcc_pkg::*;

    logic   prev_reg,  prev_next;
    time_t  tick_reg,  tick_next;
    time_t  press_reg, press_next;
    time_t  first_reg, first_next;
    count_t count_reg, count_next;

    time_t  held;
    time_t  gap;
    count_t count_inc;

    assign held      = tick_reg - press_reg;
    assign gap       = tick_reg - first_reg;
    assign count_inc = (count_reg < count_t'(2)) ? count_reg + count_t'(1) : count_reg;

    always_comb
    begin
        prev_next    = level;
        tick_next    = tick_reg + time_t'(1);
        press_next   = press_reg;
        first_next   = first_reg;
        count_next   = count_reg;
        result.valid = 1'b0;
        result.ev    = EV_SINGLE;

        if (prev_reg && !level)
        begin
            press_next = tick_reg;
        end
        else if (!prev_reg && level)
        begin
            if (held < time_t'(cfg.debounce))
            begin
                press_next = press_reg;
            end
            else if (held > time_t'(cfg.long_click))
            begin
                result.valid = 1'b1;
                result.ev    = EV_LONG;
            end
            else
            begin
                count_next = count_inc;
                if (count_inc == count_t'(1))
                begin
                    first_next = tick_reg;
                end
            end
        end
        else
        begin
            if (count_reg == count_t'(1) && gap > time_t'(cfg.double_gap))
            begin
                first_next   = '0;
                count_next   = '0;
                result.valid = 1'b1;
                result.ev    = EV_SINGLE;
            end
            else if (count_reg > count_t'(1))
            begin
                first_next   = '0;
                count_next   = '0;
                result.valid = 1'b1;
                result.ev    = EV_DOUBLE;
            end
        end

        if (!take)
        begin
            result.valid = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg  <= 1'b1;
            tick_reg  <= '0;
            press_reg <= '0;
            first_reg <= '0;
            count_reg <= '0;
        end
        else if (take)
        begin
            prev_reg  <= prev_next;
            tick_reg  <= tick_next;
            press_reg <= press_next;
            first_reg <= first_next;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/bcc_out_buf.sv =====
// ----------------------------------------------------------------------------
// bcc_out_buf
// Two-entry result queue between the classifier and the output channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bcc_out_buf (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire bcc_pkg::bcc_result_t push,
    output logic                   full,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [1:0]             click_event
);
    import bcc_pkg::*;

    click_ev_t  mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg,  count_next;
    logic       pop;

    assign pop         = out_valid && !out_stall;
    assign full        = count_reg == 2'd2;
    assign out_valid   = count_reg != 2'd0;
    assign click_event = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push.valid ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push.valid} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            mem[wr_ptr_reg] <= push.ev;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== tb/tb_button_click_classifier.sv =====
// ----------------------------------------------------------------------------
// tb_button_click_classifier
// Self-checking testbench for the button click classifier.
// ----------------------------------------------------------------------------
// Drives one button level word per tick. A short scripted sequence covers
// bounce, single, long and double clicks, a double click reported while the
// button is held, and a zero-debounce double click. Randomized press/release
// sequences follow, shaped around the current thresholds, under several
// threshold settings including the all-zero and all-ones corners. Every
// accepted word runs through an in-bench classifier, and each click_event
// the block delivers is compared in order against the expected events.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_button_click_classifier;

    import bcc_pkg::*;

    localparam int CLK_HALF       = 4;
    localparam int RESET_CYCLES   = 2;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASES         = 12;
    localparam int PHASE_WORDS    = 100;
    localparam int LEN_CAP        = 320;
    localparam int N_ROWS         = 37;

    typedef enum logic {ROW_WRITE, ROW_TICK} row_kind_t;

    typedef struct packed {
        row_kind_t kind;
        logic      level;
        logic      fixed;
        logic      fixed_has;
        click_ev_t fixed_ev;
        cfg_idx_t  reg_idx;
        cfg_word_t value;
    } step_row_t;

    logic      clk          = 1'b0;
    logic      rst_n        = 1'b0;
    logic      in_valid     = 1'b0;
    logic      in_stall;
    logic      button_level = 1'b1;
    logic      out_valid;
    logic      out_stall    = 1'b0;
    logic [1:0] click_event;
    logic      cfg_we       = 1'b0;
    cfg_idx_t  cfg_index    = REG_DEBOUNCE;
    cfg_word_t cfg_data     = '0;

    logic      fixed_on  = 1'b0;
    logic      fixed_has = 1'b0;
    click_ev_t fixed_ev  = EV_SINGLE;

    int src_idle_pct  = 0;
    int dst_stall_pct = 0;
    int items_sent    = 0;
    int mismatches    = 0;
    int quiet_cycles  = 0;

    // classifier state, reset values
    bcc_cfg_t thr            = '{DEBOUNCE_RESET, LONG_CLICK_RESET, DOUBLE_GAP_RESET};
    logic     last_level     = 1'b1;
    time_t    tick_count     = '0;
    time_t    press_at       = '0;
    time_t    first_click_at = '0;
    count_t   click_cnt      = '0;

    click_ev_t pending_events [$];

    bcc_cfg_t corner_cfg [4] = '{
        '{16'd0,     16'd0,     16'd0},
        '{16'hFFFF,  16'hFFFF,  16'hFFFF},
        '{16'd0,     16'hFFFF,  16'hFFFF},
        '{DEBOUNCE_RESET, LONG_CLICK_RESET, DOUBLE_GAP_RESET}
    };

    step_row_t walk_rows [N_ROWS] = '{
        '{ROW_WRITE, 1'b1, 1'b0, 1'b0, EV_SINGLE, REG_DEBOUNCE,   16'd2},
        '{ROW_WRITE, 1'b1, 1'b0, 1'b0, EV_SINGLE, REG_LONG_CLICK, 16'd4},
        '{ROW_WRITE, 1'b1, 1'b0, 1'b0, EV_SINGLE, REG_DOUBLE_GAP, 16'd3},
        '{ROW_TICK,  1'b1, 1'b1, 1'b0, EV_SINGLE, REG_DEBOUNCE,   16'd0},
        '{ROW_TICK,  1'b0, 1'b0, 1'b0, EV_SINGLE, REG_DEBOUNCE,   16'd0},
        '{ROW_TICK,  1'b1, 1'b1, 1'b0, EV_SINGLE, REG_DEBOUNCE,   16'd0},
        '{ROW_TICK,  1'b0, 1'b0, 1'b0, EV_SINGLE, REG_DEBOUNCE,   16'd0},
        '{ROW_TICK,  1'b0, 1'b0, 1'b0, EV_SINGLE, REG_DEBOUNCE,   16'd0},
        '{ROW_TICK,  1'b0, 1'b0, 1'b0, EV_SINGLE, REG_DEBOUNCE,   16'd0},
        '{ROW_TICK,  1'b1, 1'b0, 1'b0, EV_SINGLE, REG_DEBOUNCE,   16'd0},
        '{ROW_TICK,  1'b1, 1'b0, 1'b0, EV_SINGLE, REG_DEBOUNCE,   16'd0},
        '{ROW_TICK,  1'b1, 1'b0, 1'b0, EV_SINGLE, REG_DEBOUNCE,   16'd0},
        '{ROW_TICK,  1'b1, 1'b0, 1'b0, EV_SINGLE, REG_DEBOUNCE,   16'd0},
        '{ROW_TICK,  1'b1, 1'b1, 1'b1, EV_SINGLE, REG_DEBOUNCE,   16'd0},
        '{ROW_TICK,  1'b0, 1'b0, 1'b0, EV_SINGLE, REG_DEBOUNCE,   16'd0},
        '{ROW_TICK,  1'b0, 1'b0, 1'b0, EV_SINGLE, REG_DEBOUNCE,   16'd0},
        '{ROW_TICK,  1'b0, 1'b0, 1'b0, EV_SINGLE, REG_DEBOUNCE,   16'd0},
        '{ROW_TICK,  1'b0, 1'b0, 1'b0, EV_SINGLE, REG_DEBOUNCE,   16'd0},
        '{ROW_TICK,  1'b0, 1'b0, 1'b0, EV_SINGLE, REG_DEBOUNCE,   16'd0},
        '{ROW_TICK,  1'b1, 1'b1, 1'b1, EV_LONG,   REG_DEBOUNCE,   16'd0},
        '{ROW_TICK,  1'b0, 1'b0, 1'b0, EV_SINGLE, REG_DEBOUNCE,   16'd0},
        '{ROW_TICK,  1'b0, 1'b0, 1'b0, EV_SINGLE, REG_DEBOUNCE,   16'd0},
        '{ROW_TICK,  1'b1, 1'b0, 1'b0, EV_SINGLE, REG_DEBOUNCE,   16'd0},
        '{ROW_TICK,  1'b0, 1'b0, 1'b0, EV_SINGLE, REG_DEBOUNCE,   16'd0},
        '{ROW_TICK,  1'b0, 1'b0, 1'b0, EV_SINGLE, REG_DEBOUNCE,   16'd0},
        '{ROW_TICK,  1'b1, 1'b0, 1'b0, EV_SINGLE, REG_DEBOUNCE,   16'd0},
        '{ROW_TICK,  1'b0, 1'b0, 1'b0, EV_SINGLE, REG_DEBOUNCE,   16'd0},
        '{ROW_TICK,  1'b0, 1'b1, 1'b1, EV_DOUBLE, REG_DEBOUNCE,   16'd0},
        '{ROW_WRITE, 1'b1, 1'b0, 1'b0, EV_SINGLE, REG_DEBOUNCE,   16'd0},
        '{ROW_WRITE, 1'b1, 1'b0, 1'b0, EV_SINGLE, REG_LONG_CLICK, 16'hFFFF},
        '{ROW_WRITE, 1'b1, 1'b0, 1'b0, EV_SINGLE, REG_DOUBLE_GAP, 16'hFFFF},
        '{ROW_TICK,  1'b1, 1'b0, 1'b0, EV_SINGLE, REG_DEBOUNCE,   16'd0},
        '{ROW_TICK,  1'b0, 1'b0, 1'b0, EV_SINGLE, REG_DEBOUNCE,   16'd0},
        '{ROW_TICK,  1'b1, 1'b0, 1'b0, EV_SINGLE, REG_DEBOUNCE,   16'd0},
        '{ROW_TICK,  1'b0, 1'b0, 1'b0, EV_SINGLE, REG_DEBOUNCE,   16'd0},
        '{ROW_TICK,  1'b1, 1'b0, 1'b0, EV_SINGLE, REG_DEBOUNCE,   16'd0},
        '{ROW_TICK,  1'b1, 1'b1, 1'b1, EV_DOUBLE, REG_DEBOUNCE,   16'd0}
    };

    button_click_classifier DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .button_level (button_level),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .click_event  (click_event),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #CLK_HALF clk = ~clk;

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < dst_stall_pct);
    end

    task automatic classify_tick(input logic lvl, output logic hit, output click_ev_t ev);
        time_t held;
        hit = 1'b0;
        ev  = EV_SINGLE;
        if (last_level && !lvl)
        begin
            press_at = tick_count;
        end
        else if (!last_level && lvl)
        begin
            held = tick_count - press_at;
            if (held >= thr.debounce)
            begin
                if (held > thr.long_click)
                begin
                    hit = 1'b1;
                    ev  = EV_LONG;
                end
                else
                begin
                    if (click_cnt < 2)
                        click_cnt = click_cnt + 1'b1;
                    if (click_cnt == 1)
                        first_click_at = tick_count;
                end
            end
        end
        else if (click_cnt == 1 && (tick_count - first_click_at) > thr.double_gap)
        begin
            first_click_at = '0;
            click_cnt      = '0;
            hit            = 1'b1;
            ev             = EV_SINGLE;
        end
        else if (click_cnt > 1)
        begin
            first_click_at = '0;
            click_cnt      = '0;
            hit            = 1'b1;
            ev             = EV_DOUBLE;
        end
        last_level = lvl;
        tick_count = tick_count + 1'b1;
    endtask

    always @(posedge clk)
    begin : check_words
        logic      hit;
        click_ev_t ev;
        click_ev_t want;
        logic      moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if (in_valid && !in_stall)
            begin
                moved = 1'b1;
                classify_tick(button_level, hit, ev);
                if (fixed_on)
                begin
                    hit = fixed_has;
                    ev  = fixed_ev;
                end
                if (hit)
                    pending_events.push_back(ev);
            end
            if (out_valid && !out_stall)
            begin
                moved = 1'b1;
                if (pending_events.size() == 0)
                begin
                    $error("click_event unexpected: expected none, got %0d", click_event);
                    mismatches++;
                end
                else
                begin
                    want = pending_events.pop_front();
                    if (click_event !== want)
                    begin
                        $error("click_event mismatch: expected %0d, got %0d", want, click_event);
                        mismatches++;
                    end
                end
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    task automatic send_level(input logic lvl, input logic chk, input logic chk_has,
                              input click_ev_t chk_ev);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        button_level <= lvl;
        fixed_on     <= chk;
        fixed_has    <= chk_has;
        fixed_ev     <= chk_ev;
        do
            @(posedge clk);
        while (in_stall);
        items_sent++;
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_events.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input cfg_word_t val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_DEBOUNCE:   thr.debounce   = val;
            REG_LONG_CLICK: thr.long_click = val;
            REG_DOUBLE_GAP: thr.double_gap = val;
            default: ;
        endcase
    endtask

    task automatic apply_thresholds(input bcc_cfg_t c);
        settle();
        write_reg(REG_DEBOUNCE, c.debounce);
        write_reg(REG_LONG_CLICK, c.long_click);
        write_reg(REG_DOUBLE_GAP, c.double_gap);
    endtask

    task automatic play_sequence();
        int unsigned d;
        int unsigned lg;
        int unsigned g;
        int unsigned lo;
        int unsigned pick;
        int unsigned hold;
        int unsigned rel;
        d    = thr.debounce;
        lg   = thr.long_click;
        g    = thr.double_gap;
        lo   = (d == 0) ? 1 : d;
        pick = $urandom_range(0, 9);
        if (pick == 0)
        begin
            repeat ($urandom_range(1, 8))
                send_level($urandom_range(0, 1), 1'b0, 1'b0, EV_SINGLE);
            return;
        end
        if (pick < 3)
            hold = (d >= 2) ? $urandom_range(1, (d - 1 < 12) ? d - 1 : 12) : 1;
        else if (pick < 8 && lo <= lg && lo <= LEN_CAP)
            hold = $urandom_range(lo, (lg < lo + 12) ? lg : lo + 12);
        else if (pick >= 8 && lg < LEN_CAP)
            hold = $urandom_range(lg + 1, lg + 4);
        else
            hold = $urandom_range(1, 6);
        if ($urandom_range(0, 9) < 6 || g >= LEN_CAP)
            rel = $urandom_range(1, 4);
        else
            rel = $urandom_range((g == 0) ? 1 : g, g + 3);
        repeat (hold) send_level(1'b0, 1'b0, 1'b0, EV_SINGLE);
        repeat (rel) send_level(1'b1, 1'b0, 1'b0, EV_SINGLE);
    endtask

    initial
    begin
        int       i;
        int       p;
        int       rg;
        int       start;
        bcc_cfg_t c;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        src_idle_pct  = 34;
        dst_stall_pct = 48;
        for (i = 0; i < N_ROWS; i++)
        begin
            if (walk_rows[i].kind == ROW_WRITE)
            begin
                settle();
                write_reg(walk_rows[i].reg_idx, walk_rows[i].value);
            end
            else
            begin
                send_level(walk_rows[i].level, walk_rows[i].fixed,
                           walk_rows[i].fixed_has, walk_rows[i].fixed_ev);
            end
        end

        for (p = 0; p < PHASES; p++)
        begin
            rg = p / (PHASES / 3);
            case (rg)
                0:
                begin
                    src_idle_pct  = 34;
                    dst_stall_pct = 48;
                end
                1:
                begin
                    src_idle_pct  = 48;
                    dst_stall_pct = 34;
                end
                default:
                begin
                    src_idle_pct  = 0;
                    dst_stall_pct = 0;
                end
            endcase
            if (p % 4 == 0)
                c = corner_cfg[rg];
            else if (p == PHASES - 1)
                c = corner_cfg[3];
            else if (p % 4 == 2)
            begin
                c.debounce   = $urandom_range(0, 6);
                c.long_click = $urandom_range(0, 16'hFFFF);
                c.double_gap = $urandom_range(0, 16'hFFFF);
            end
            else
            begin
                c.debounce   = $urandom_range(0, 6);
                c.long_click = $urandom_range(0, 14);
                c.double_gap = $urandom_range(0, 12);
            end
            apply_thresholds(c);
            start = items_sent;
            while (items_sent - start < PHASE_WORDS)
                play_sequence();
        end

        settle();
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
